### rtl/psph_pkg.sv
// ----------------------------------------------------------------------------
// psph_pkg: shared types and constants of the PC sampling histogram
// Function codes, register indexes, LCG constants and width helpers.
// ----------------------------------------------------------------------------
package psph_pkg;

  localparam int unsigned REGIONS_DEF = 8;
  localparam int unsigned BUCKETS_DEF = 4096;

  localparam logic [31:0] LCG_MUL  = 32'd1664525;
  localparam logic [31:0] LCG_INC  = 32'd1013904223;
  localparam logic [31:0] LCG_SEED = 32'hDEADBEEF;

  localparam logic [15:0] RANDOM_DROP_MAX = 16'd16383;
  localparam logic [7:0]  WEIGHT_MAX      = 8'd255;
  localparam int unsigned SCALE_SHIFT     = 17;
  localparam logic [17:0] SPECIAL_SCALE   = 18'h2;

  // Region descriptor as stored: {base, scale, bytes}
  localparam int unsigned REG_W = 64 + 18 + 32;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_LOAD   = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    CFG_BUCKET_WIDTH  = 3'd0,
    CFG_RANDOM_EN     = 3'd1,
    CFG_COMPRESS_EN   = 3'd2,
    CFG_WEIGHTED_EN   = 3'd3,
    CFG_THRESHOLD     = 3'd4,
    CFG_REGION_COUNT  = 3'd5,
    CFG_SPARE6        = 3'd6,
    CFG_SPARE7        = 3'd7
  } cfg_idx_t;

  localparam logic [1:0] BW_16 = 2'd0;
  localparam logic [1:0] BW_32 = 2'd1;

  function automatic logic [63:0] width_mask(input logic [1:0] bw);
    logic [63:0] m;
    case (bw)
      BW_16:   m = 64'h0000_0000_0000_FFFF;
      BW_32:   m = 64'h0000_0000_FFFF_FFFF;
      default: m = '1;
    endcase
    return m;
  endfunction

  function automatic logic [1:0] width_shift(input logic [1:0] bw);
    logic [1:0] s;
    case (bw)
      BW_16:   s = 2'd1;
      BW_32:   s = 2'd2;
      default: s = 2'd3;
    endcase
    return s;
  endfunction

endpackage

### rtl/pc_sample_profile_histogram.sv
// A sample searches the N active regions and forms a bucket index; if in range,
// it reads the bucket, runs each enabled draw and, for a weighted increment, may
// run the serial divide; N = active regions. One transaction at a time; the region
// search loop and the serial divider set the rate.
// Reset: configuration registers zero, LCG reseeded, region table invalidated;
// then a clearing pass zeroes all REGIONS*BUCKETS bucket entries (no input taken).
// ----------------------------------------------------------------------------
// pc_sample_profile_histogram: program-counter sampling histogram
// Region search, bucket index, gated/weighted increment, bucket readback.
// ----------------------------------------------------------------------------
module pc_sample_profile_histogram #(
  parameter int unsigned REGIONS = psph_pkg::REGIONS_DEF,
  parameter int unsigned BUCKETS = psph_pkg::BUCKETS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [63:0] pc,
  input  logic [61:0] excess,
  input  logic [2:0]  region_sel,
  input  logic [63:0] base_address,
  input  logic [17:0] scale_factor,
  input  logic [31:0] size_bytes,
  input  logic [11:0] bucket_sel,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  region_used,
  output logic [63:0] bucket_index,
  output logic [63:0] bucket_value,
  output logic [7:0]  increment,
  output logic        in_range
);
  import psph_pkg::*;

  localparam int unsigned RIW   = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int unsigned RCW   = $clog2(REGIONS + 1);
  localparam int unsigned DEPTH = REGIONS * BUCKETS;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [17:0] {
    S_CLEAR = 18'h00001, S_IDLE = 18'h00002, S_RRD  = 18'h00004,
    S_RCMP  = 18'h00008, S_BEST = 18'h00010, S_RGET = 18'h00020,
    S_MUL0  = 18'h00040, S_MUL1 = 18'h00080, S_IDX  = 18'h00100,
    S_RNG   = 18'h00200, S_BRD  = 18'h00400, S_BGET = 18'h00800,
    S_DRAWR = 18'h01000, S_DRAWC = 18'h02000, S_WGT = 18'h04000,
    S_DIV   = 18'h08000, S_WB   = 18'h10000, S_DONE = 18'h20000
  } state_t;

  state_t state;

  // configuration registers
  logic [1:0]  bucket_width;
  logic        random_enable, compress_enable, weighted_enable;
  logic [30:0] weight_threshold;
  logic [3:0]  region_count;

  // latched transaction
  func_t       func_q;
  logic [63:0] pc_q;
  logic [61:0] excess_q;

  // working registers
  logic [31:0]   lcg;
  logic [RCW-1:0] rcnt;
  logic [RIW-1:0] best;
  logic [63:0]   best_base;
  logic [63:0]   diff;
  logic [17:0]   scale_q;
  logic [31:0]   bytes_q;
  logic          base_ok, special;
  logic [49:0]   plo;
  logic [31:0]   phi;
  logic [63:0]   idx;
  logic [AW-1:0] slot;
  logic [AW-1:0] clr_addr;
  logic [63:0]   cur;
  logic [7:0]    inc;
  logic [2:0]    r_region;
  logic [63:0]   r_idx, r_val;
  logic          r_rng;

  // serial divider
  logic [31:0] dv_rem;
  logic [30:0] dv_quo, dv_den;
  logic [4:0]  dv_cnt;

  // region table RAM with per-entry valid bits
  logic [REGIONS-1:0] region_valid;
  logic               rg_we, rg_vld_q;
  logic [RIW-1:0]     rg_waddr, rg_raddr;
  logic [REG_W-1:0]   rg_wdata, rg_rdata, rg_data;

  // bucket RAM
  logic          bk_we;
  logic [AW-1:0] bk_waddr;
  logic [63:0]   bk_wdata, bk_rdata;

  psph_ram #(.WIDTH(REG_W), .DEPTH(REGIONS)) u_region_ram (
    .clk(clk), .we(rg_we), .waddr(rg_waddr), .wdata(rg_wdata),
    .raddr(rg_raddr), .rdata(rg_rdata)
  );

  psph_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_bucket_ram (
    .clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
    .raddr(slot), .rdata(bk_rdata)
  );

  // handshakes
  logic in_acc, out_free;
  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // combinational helpers
  logic [RCW-1:0] n_regions;
  logic [63:0]    mask, rg_base, new_val;
  logic [17:0]    rg_scale;
  logic [31:0]    rg_bytes;
  logic [1:0]     wsh;
  logic [32:0]    limit;
  logic [31:0]    lcg_next;
  logic [31:0]    dv_r, dv_rem_n;
  logic [30:0]    dv_quo_n;
  logic           dv_ge;
  logic           load_ok, read_ok;
  logic [62:0]    thr_prod;
  logic [23:0]    thr_div;

  always_comb begin
    n_regions = (32'(region_count) > REGIONS) ? RCW'(REGIONS) : RCW'(region_count);
    mask      = width_mask(bucket_width);
    wsh       = width_shift(bucket_width);
    rg_data   = rg_vld_q ? rg_rdata : '0;
    rg_base   = rg_data[REG_W-1 -: 64];
    rg_scale  = rg_data[49:32];
    rg_bytes  = rg_data[31:0];
    limit     = ({1'b0, bytes_q} + ((33'd1 << wsh) - 33'd1)) >> wsh;
    lcg_next  = lcg * LCG_MUL + LCG_INC;
    new_val   = (cur + {56'd0, inc}) & mask;
    dv_r      = {dv_rem[30:0], dv_quo[30]};
    dv_ge     = dv_r >= {1'b0, dv_den};
    dv_rem_n  = dv_ge ? dv_r - {1'b0, dv_den} : dv_r;
    dv_quo_n  = {dv_quo[29:0], dv_ge};
    load_ok   = 32'(region_sel) < REGIONS;
    read_ok   = load_ok && (32'(bucket_sel) < BUCKETS);
    // threshold / 255 by reciprocal multiply (exact for 32-bit dividends)
    thr_prod  = 63'({33'd0, weight_threshold} * 64'h0000_0000_8080_8081);
    thr_div   = thr_prod[62:39];
  end

  // RAM port selection
  always_comb begin
    rg_we    = in_acc && (func == FUNC_LOAD) && load_ok;
    rg_waddr = RIW'(region_sel);
    rg_wdata = {base_address, scale_factor, size_bytes};
    rg_raddr = (state == S_RRD) ? RIW'(rcnt) : best;
    bk_we    = (state == S_CLEAR) || (state == S_WB);
    bk_waddr = (state == S_CLEAR) ? clr_addr : slot;
    bk_wdata = (state == S_CLEAR) ? 64'd0 : new_val;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_width     <= '0;
      random_enable    <= 1'b0;
      compress_enable  <= 1'b0;
      weighted_enable  <= 1'b0;
      weight_threshold <= '0;
      region_count     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BUCKET_WIDTH: bucket_width     <= cfg_data[1:0];
        CFG_RANDOM_EN:    random_enable    <= cfg_data[0];
        CFG_COMPRESS_EN:  compress_enable  <= cfg_data[0];
        CFG_WEIGHTED_EN:  weighted_enable  <= cfg_data[0];
        CFG_THRESHOLD:    weight_threshold <= cfg_data;
        CFG_REGION_COUNT: region_count     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // region valid bits and registered valid for read
  always_ff @(posedge clk) begin
    if (rst) begin
      region_valid <= '0;
    end else if (rg_we) begin
      region_valid[rg_waddr] <= 1'b1;
    end
    rg_vld_q <= region_valid[rg_raddr];
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      lcg       <= LCG_SEED;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == DEPTH - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            func_q    <= func_t'(func);
            pc_q      <= pc;
            excess_q  <= excess;
            r_region  <= '0;
            r_idx     <= '0;
            r_val     <= '0;
            r_rng     <= 1'b0;
            inc       <= '0;
            rcnt      <= '0;
            best      <= '0;
            best_base <= '0;
            unique case (func_t'(func))
              FUNC_SAMPLE: state <= (n_regions == '0) ? S_BEST : S_RRD;
              FUNC_LOAD: begin
                r_region <= region_sel;
                state    <= S_DONE;
              end
              FUNC_READ: begin
                r_region <= region_sel;
                r_idx    <= {52'd0, bucket_sel};
                slot     <= AW'(AW'(region_sel) * AW'(BUCKETS) + AW'(bucket_sel));
                state    <= read_ok ? S_BRD : S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        // region search, one entry per read/compare pair
        S_RRD: state <= S_RCMP;
        S_RCMP: begin
          if (rg_base < pc_q && rg_base > best_base) begin
            best      <= RIW'(rcnt);
            best_base <= rg_base;
          end
          rcnt  <= rcnt + 1'b1;
          state <= (rcnt + 1'b1 == n_regions) ? S_BEST : S_RRD;
        end
        S_BEST: state <= S_RGET;
        S_RGET: begin
          diff    <= pc_q - rg_base;
          scale_q <= rg_scale;
          bytes_q <= rg_bytes;
          base_ok <= pc_q >= rg_base;
          special <= (rg_base == 64'd0) && (rg_scale == SPECIAL_SCALE);
          state   <= S_MUL0;
        end
        // 64x18 product as two 32x18 partial products
        S_MUL0: begin
          plo   <= diff[31:0] * scale_q;
          state <= S_MUL1;
        end
        S_MUL1: begin
          phi   <= 32'(diff[63:32] * scale_q);
          state <= S_IDX;
        end
        S_IDX: begin
          idx   <= special ? 64'd0
                   : (({14'd0, plo} + {phi, 32'd0}) >> SCALE_SHIFT);
          state <= S_RNG;
        end
        S_RNG: begin
          r_region <= 3'(best);
          r_idx    <= idx;
          slot     <= AW'(AW'(best) * AW'(BUCKETS) + AW'(idx));
          if (base_ok && idx < {31'd0, limit} && idx < 64'(BUCKETS)) begin
            state <= S_BRD;
          end else begin
            state <= S_DONE;
          end
        end
        S_BRD: state <= S_BGET;
        S_BGET: begin
          cur <= bk_rdata & mask;
          if (func_q == FUNC_READ) begin
            r_val <= bk_rdata & mask;
            r_rng <= 1'b1;
            state <= S_DONE;
          end else if (random_enable) begin
            state <= S_DRAWR;
          end else if (compress_enable) begin
            state <= S_DRAWC;
          end else if (weighted_enable) begin
            state <= S_WGT;
          end else begin
            inc   <= 8'd1;
            state <= S_WB;
          end
        end
        // increment gating draws
        S_DRAWR: begin
          lcg <= lcg_next;
          if (lcg_next[15:0] <= RANDOM_DROP_MAX) begin
            inc   <= 8'd0;
            state <= S_WB;
          end else if (compress_enable) begin
            state <= S_DRAWC;
          end else if (weighted_enable) begin
            state <= S_WGT;
          end else begin
            inc   <= 8'd1;
            state <= S_WB;
          end
        end
        S_DRAWC: begin
          lcg <= lcg_next;
          if ({48'd0, lcg_next[15:0]} < cur) begin
            inc   <= 8'd0;
            state <= S_WB;
          end else if (weighted_enable) begin
            state <= S_WGT;
          end else begin
            inc   <= 8'd1;
            state <= S_WB;
          end
        end
        S_WGT: begin
          if (excess_q <= 62'd1) begin
            inc   <= 8'd1;
            state <= S_WB;
          end else if (excess_q > {31'd0, weight_threshold}) begin
            inc   <= WEIGHT_MAX;
            state <= S_WB;
          end else if (thr_div == '0) begin
            inc   <= WEIGHT_MAX;
            state <= S_WB;
          end else begin
            // excess fits 31 bits here since it is at most the threshold
            dv_rem <= '0;
            dv_quo <= excess_q[30:0];
            dv_den <= {7'd0, thr_div};
            dv_cnt <= '0;
            state  <= S_DIV;
          end
        end
        // restoring divider, one quotient bit per cycle
        S_DIV: begin
          dv_rem <= dv_rem_n;
          dv_quo <= dv_quo_n;
          dv_cnt <= dv_cnt + 1'b1;
          if (dv_cnt == 5'd30) begin
            if (dv_quo_n == '0) begin
              inc <= 8'd1;
            end else if (dv_quo_n > 31'(WEIGHT_MAX)) begin
              inc <= WEIGHT_MAX;
            end else begin
              inc <= dv_quo_n[7:0];
            end
            state <= S_WB;
          end
        end
        S_WB: begin
          r_val <= new_val;
          r_rng <= 1'b1;
          state <= S_DONE;
        end
        // hand result to the output register
        S_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            region_used  <= r_region;
            bucket_index <= r_idx;
            bucket_value <= r_val;
            increment    <= r_rng ? inc : 8'd0;
            in_range     <= r_rng;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/psph_ram.sv
// ----------------------------------------------------------------------------
// psph_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module psph_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### bench/psph_checker.sv
// ----------------------------------------------------------------------------
// psph_checker: scoreboard for the PC sampling histogram
// Watches the config, input and output channels. It predicts each result from
// its own copy of the registers, region table, bucket store and LCG, then
// compares the results in order.
// ----------------------------------------------------------------------------
module psph_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  func,
  input  logic [63:0] pc,
  input  logic [61:0] excess,
  input  logic [2:0]  region_sel,
  input  logic [63:0] base_address,
  input  logic [17:0] scale_factor,
  input  logic [31:0] size_bytes,
  input  logic [11:0] bucket_sel,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  region_used,
  input  logic [63:0] bucket_index,
  input  logic [63:0] bucket_value,
  input  logic [7:0]  increment,
  input  logic        in_range,
  output int          fail_count,
  output int          pending
);
  import psph_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  region;
    logic [63:0] index;
    logic [63:0] value;
    logic [7:0]  inc;
    logic        hit;
  } hist_result_t;

  // shadow registers
  logic [1:0]  bw;
  logic        rnd_en, cmp_en, wgt_en;
  logic [30:0] thresh;
  logic [3:0]  rcount;

  // shadow state
  logic [31:0] lcg;
  logic [63:0] rbase [REGIONS_DEF];
  logic [17:0] rscale[REGIONS_DEF];
  logic [31:0] rbytes[REGIONS_DEF];
  logic [63:0] counts[REGIONS_DEF * BUCKETS_DEF];

  hist_result_t expected_q[$];

  function automatic logic [15:0] next_draw();
    lcg = lcg * LCG_MUL + LCG_INC;
    return lcg[15:0];
  endfunction

  function automatic logic [7:0] weight(input logic [63:0] ex);
    logic [63:0] div, q;
    if (ex <= 1) return 8'd1;
    if (ex > {33'd0, thresh}) return WEIGHT_MAX;
    div = {33'd0, thresh} / 64'd255;
    if (div == 0) return WEIGHT_MAX;
    q = ex / div;
    if (q < 1) q = 1;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  // Work out the result of one input transaction and update the shadow state.
  function automatic hist_result_t histogram_step(
    input logic [1:0] f, input logic [63:0] p, input logic [61:0] ex,
    input logic [2:0] rs, input logic [63:0] ba, input logic [17:0] sc,
    input logic [31:0] sz, input logic [11:0] bs);
    hist_result_t r;
    int unsigned n, best, sh;
    logic [63:0] best_base, base, idx, lim, mask, cur;
    logic [7:0]  inc;
    r = '0;
    mask = (bw == BW_16) ? 64'hFFFF : (bw == BW_32) ? 64'hFFFF_FFFF : '1;
    sh = (bw == BW_16) ? 1 : (bw == BW_32) ? 2 : 3;
    case (func_t'(f))
      FUNC_SAMPLE: begin
        n = (rcount > REGIONS_DEF) ? REGIONS_DEF : rcount;
        best = 0;
        best_base = 0;
        for (int i = 0; i < n; i++) begin
          if (rbase[i] < p && rbase[i] > best_base) begin
            best = i;
            best_base = rbase[i];
          end
        end
        base = rbase[best];
        if (base == 0 && rscale[best] == SPECIAL_SCALE) idx = 0;
        else idx = ((p - base) * {46'd0, rscale[best]}) >> SCALE_SHIFT;
        r.region = best[2:0];
        r.index = idx;
        lim = ({32'd0, rbytes[best]} + ((64'd1 << sh) - 1)) >> sh;
        if (p >= base && idx < lim && idx < BUCKETS_DEF) begin
          cur = counts[best * BUCKETS_DEF + idx] & mask;
          // drop draws come first, weighting last
          if (rnd_en && next_draw() <= RANDOM_DROP_MAX) inc = 0;
          else if (cmp_en && {48'd0, next_draw()} < cur) inc = 0;
          else if (wgt_en) inc = weight({2'b0, ex});
          else inc = 1;
          cur = (cur + inc) & mask;
          counts[best * BUCKETS_DEF + idx] = cur;
          r.value = cur;
          r.inc = inc;
          r.hit = 1'b1;
        end
      end
      FUNC_LOAD: begin
        r.region = rs;
        rbase[rs] = ba;
        rscale[rs] = sc;
        rbytes[rs] = sz;
      end
      FUNC_READ: begin
        r.region = rs;
        r.index = {52'd0, bs};
        r.value = counts[rs * BUCKETS_DEF + bs] & mask;
        r.hit = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    hist_result_t got, want;
    if (rst) begin
      bw <= '0; rnd_en <= 0; cmp_en <= 0; wgt_en <= 0; thresh <= '0; rcount <= '0;
      lcg = LCG_SEED;
      for (int i = 0; i < REGIONS_DEF; i++) begin
        rbase[i] = '0; rscale[i] = '0; rbytes[i] = '0;
      end
      for (int i = 0; i < REGIONS_DEF * BUCKETS_DEF; i++) counts[i] = '0;
      expected_q.delete();
      pending = 0;
      fail_count <= 0;
    end else begin
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_BUCKET_WIDTH: bw <= cfg_data[1:0];
          CFG_RANDOM_EN:    rnd_en <= cfg_data[0];
          CFG_COMPRESS_EN:  cmp_en <= cfg_data[0];
          CFG_WEIGHTED_EN:  wgt_en <= cfg_data[0];
          CFG_THRESHOLD:    thresh <= cfg_data;
          CFG_REGION_COUNT: rcount <= cfg_data[3:0];
          default: ;
        endcase
      end
      // input transaction
      if (in_valid && !in_stall)
        expected_q.push_back(histogram_step(func, pc, excess, region_sel, base_address,
                                            scale_factor, size_bytes, bucket_sel));
      // output transaction
      if (out_valid && !out_stall) begin
        got = '{region_used, bucket_index, bucket_value, increment, in_range};
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: expected %p actual %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending = expected_q.size();
    end
  end
endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: PC sampling histogram
// Drives directed and random transactions through several register settings
// and idling patterns. A checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import psph_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // the bucket clearing pass after reset takes no input and so counts as quiet time
  localparam int WATCHDOG_LIMIT = 150000;

  logic        clk, rst;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [30:0] cfg_data;
  logic        in_valid, in_stall;
  logic [1:0]  func;
  logic [63:0] pc;
  logic [61:0] excess;
  logic [2:0]  region_sel;
  logic [63:0] base_address;
  logic [17:0] scale_factor;
  logic [31:0] size_bytes;
  logic [11:0] bucket_sel;
  logic        out_valid, out_stall;
  logic [2:0]  region_used;
  logic [63:0] bucket_index, bucket_value;
  logic [7:0]  increment;
  logic        in_range;
  int          fail_count, pending;

  int          send_idle_pct, stall_pct;
  bit          long_hold_req, long_hold_done;
  logic [63:0] known_base[REGIONS_DEF];

  pc_sample_profile_histogram dut (.*);
  psph_checker chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // receiver: random stall, plus one long hold-off
  initial begin
    out_stall = 1'b0;
    long_hold_done = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold_done = 1;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // watchdog: cycles with no transaction on any channel
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [30:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic send(input func_t f, input logic [63:0] p, input logic [61:0] ex,
                      input logic [2:0] rs, input logic [63:0] ba, input logic [17:0] sc,
                      input logic [31:0] sz, input logic [11:0] bs);
    in_valid <= 1'b1;
    func <= f; pc <= p; excess <= ex; region_sel <= rs;
    base_address <= ba; scale_factor <= sc; size_bytes <= sz; bucket_sel <= bs;
    if (f == FUNC_LOAD) known_base[rs] = ba;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // one random transaction, mostly samples that land in a loaded region
  task automatic send_random();
    int unsigned k, r;
    logic [63:0] p;
    logic [17:0] sc;
    logic [31:0] sz;
    logic [61:0] ex;
    k = $urandom_range(0, 99);
    r = $urandom_range(0, 7);
    case ($urandom_range(0, 3))
      0: ex = 62'($urandom_range(0, 3));
      1: ex = 62'($urandom_range(0, 5000));
      2: ex = 62'($urandom);
      default: ex = 62'(rand64());
    endcase
    if (k < 70) begin
      p = (k < 8) ? rand64() : known_base[r] + 64'($urandom_range(0, 12000));
      send(FUNC_SAMPLE, p, ex, 3'($urandom), rand64(), 18'($urandom), $urandom, 12'($urandom));
    end else if (k < 82) begin
      case ($urandom_range(0, 4))
        0: sc = 18'd65536;
        1: sc = 18'd131072;
        2: sc = SPECIAL_SCALE;
        3: sc = 18'd32768;
        default: sc = 18'($urandom);
      endcase
      sz = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 20000);
      p = ($urandom_range(0, 9) == 0) ? rand64() : 64'($urandom_range(0, 40)) << 14;
      send(FUNC_LOAD, rand64(), ex, 3'(r), p, sc, sz, 12'($urandom));
    end else if (k < 95) begin
      send(FUNC_READ, rand64(), ex, 3'(r), rand64(), 18'($urandom), $urandom,
           ($urandom_range(0, 1) != 0) ? 12'($urandom_range(0, 64)) : 12'($urandom));
    end else begin
      send(FUNC_NONE, rand64(), ex, 3'(r), rand64(), 18'($urandom), $urandom, 12'($urandom));
    end
  endtask

  task automatic configure(input logic [1:0] bw, input bit rnd, input bit cmp,
                           input bit wgt, input logic [30:0] thr, input logic [3:0] rc);
    write_reg(CFG_BUCKET_WIDTH, {29'd0, bw});
    write_reg(CFG_RANDOM_EN, {30'd0, rnd});
    write_reg(CFG_COMPRESS_EN, {30'd0, cmp});
    write_reg(CFG_WEIGHTED_EN, {30'd0, wgt});
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_REGION_COUNT, {27'd0, rc});
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; func = '0; pc = '0; excess = '0; region_sel = '0;
    base_address = '0; scale_factor = '0; size_bytes = '0; bucket_sel = '0;
    send_idle_pct = 0; stall_pct = 0; long_hold_req = 0;
    for (int i = 0; i < REGIONS_DEF; i++) known_base[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: region table edges and basic operations
    configure(BW_16, 0, 0, 0, 31'd0, 4'd8);
    send(FUNC_SAMPLE, 64'h10, 0, 0, 0, 0, 0, 0);
    send(FUNC_LOAD, 0, 0, 3'd0, 64'd0, SPECIAL_SCALE, 32'd100, 0);
    send(FUNC_LOAD, 0, 0, 3'd1, 64'h10000, 18'd65536, 32'd8192, 0);
    send(FUNC_LOAD, 0, 0, 3'd2, 64'hFFFF_FFFF_FFFF_0000, 18'd131072, 32'hFFFF_FFFF, 0);
    send(FUNC_LOAD, 0, 0, 3'd3, 64'h20000, 18'd0, 32'd0, 0);
    for (int r = 4; r < 8; r++)
      send(FUNC_LOAD, 0, 0, 3'(r), 64'(r + 2) << 16, 18'h3FFFF, 32'd4096, 0);
    send(FUNC_SAMPLE, 64'd0, 0, 0, 0, 0, 0, 0);
    send(FUNC_SAMPLE, 64'd5, 0, 0, 0, 0, 0, 0);
    send(FUNC_SAMPLE, 64'h10000, 0, 0, 0, 0, 0, 0);
    send(FUNC_SAMPLE, 64'h10010, '1, 0, 0, 0, 0, 0);
    send(FUNC_SAMPLE, 64'h14000, 0, 0, 0, 0, 0, 0);
    send(FUNC_SAMPLE, '1, 0, 0, 0, 0, 0, 0);
    send(FUNC_SAMPLE, 64'h20100, 0, 0, 0, 0, 0, 0);
    send(FUNC_READ, 0, 0, 3'd1, 0, 0, 0, 12'd8);
    send(FUNC_READ, 0, 0, 3'd7, 0, 0, 0, 12'd4095);
    send(FUNC_READ, 0, 0, 3'd0, 0, 0, 0, 12'd0);
    send(FUNC_NONE, '1, '1, 3'd7, '1, '1, '1, '1);
    drain();

    // random phases, each with its own settings and idling
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin configure(BW_16, 0, 0, 0, 31'd0, 4'd8);
                 send_idle_pct = 0;  stall_pct = 0;  end
        1: begin configure(BW_32, 1, 0, 1, 31'd1000, 4'd3);
                 send_idle_pct = 59; stall_pct = 0;  end
        2: begin configure(2'd2, 0, 1, 1, 31'h7FFF_FFFF, 4'd15);
                 send_idle_pct = 0;  stall_pct = 59; end
        3: begin configure(2'd3, 1, 1, 1, 31'd100, 4'd0);
                 send_idle_pct = 37; stall_pct = 37; end
        default: begin configure(BW_16, 0, 0, 1, 31'd254, 4'd8);
                 send_idle_pct = 0;  stall_pct = 0;  end
      endcase
      // weight edges: excess zero, one, two and the maximum
      send(FUNC_SAMPLE, 64'h10010, 62'd0, 0, 0, 0, 0, 0);
      send(FUNC_SAMPLE, 64'h10010, 62'd1, 0, 0, 0, 0, 0);
      send(FUNC_SAMPLE, 64'h10012, 62'd2, 0, 0, 0, 0, 0);
      send(FUNC_SAMPLE, 64'h10014, '1, 0, 0, 0, 0, 0);
      if (ph == 4) long_hold_req = 1;
      for (int i = 0; i < 185; i++) send_random();
      drain();
    end

    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
